### design/lwcu_pkg.sv
// Package for the lattice wave cell update block.
// Holds the configuration struct, the stage hand-off struct and the shared helpers.
// No dependencies.
package lwcu_pkg;

	localparam int unsigned CFG_W = 12;
	localparam logic [CFG_W-1:0] RESET_MAX_RADIUS = 12'd64;
	localparam logic signed [31:0] FORCE_LEVEL = 32'sd16384;

	// fixed-point reciprocals, exact over the 12-bit register range
	localparam logic [15:0] RECIP_25 = 16'd41944; // 2^20 / 25, rounded up
	localparam logic [15:0] RECIP_5 = 16'd52429;  // 2^18 / 5, rounded up
	localparam logic [15:0] RECIP_27 = 16'd38837; // 2^20 / 27, rounded up

	typedef struct packed {
		logic [CFG_W-1:0] radius_max; // register value, zero taken as one
		logic [9:0] shell_r;
		logic [9:0] shell_w;
		logic [7:0] absorb_w;
		logic [2:0] div_shift;
	} cfg_t;

	// what the front half hands to the back half
	typedef struct packed {
		logic [31:0] un;
		logic [31:0] vd;
		logic [31:0] force_v;
		logic [4:0] abs_shift;
		logic abs_kill;
		logic dead;
		logic active;
		logic [13:0] tick_inc;
	} front_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
		return 32'($signed(x) >>> s);
	endfunction

	function automatic cfg_t derive_cfg(input logic [CFG_W-1:0] w);
		logic [CFG_W-1:0] r;
		logic [14:0] r6;
		logic [30:0] p_sr;
		logic [27:0] p_sw;
		logic [27:0] p_aw;
		logic [7:0] aw;
		cfg_t c;
		r = (w == '0) ? 12'd1 : w;
		r6 = 15'({r, 2'b00}) + 15'({r, 1'b0});
		p_sr = 31'(r6) * 31'(RECIP_25);
		p_sw = 28'(r) * 28'(RECIP_5);
		p_aw = 28'(r) * 28'(RECIP_27);
		aw = p_aw[27:20];
		c.radius_max = r;
		c.shell_r = p_sr[29:20];
		c.shell_w = (p_sw[27:18] == '0) ? 10'd1 : p_sw[27:18];
		c.absorb_w = (aw > 8'd2) ? aw : 8'd2;
		if (r >= 12'd384) begin
			c.div_shift = 3'd6;
		end else if (r >= 12'd192) begin
			c.div_shift = 3'd5;
		end else if (r >= 12'd96) begin
			c.div_shift = 3'd4;
		end else if (r >= 12'd40) begin
			c.div_shift = 3'd3;
		end else begin
			c.div_shift = 3'd2;
		end
		return c;
	endfunction

endpackage

### design/lwcu_cfg.sv
// Configuration register for the lattice wave cell update block.
// Stores the sphere radius together with the shell, absorber and shift values it sets.
// Depends on lwcu_pkg.
module lwcu_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lwcu_pkg::CFG_W-1:0] cfg_data,
	output lwcu_pkg::cfg_t cfg
);
	import lwcu_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// derived values are worked out once, at the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= derive_cfg(RESET_MAX_RADIUS);
		end else if (cfg_valid) begin
			cfg_q <= derive_cfg(cfg_data);
		end
	end

endmodule

### design/lwcu_front.sv
// Front half of the cell update pipeline, stages 1 to 5: neighbor sum, Laplacian,
// velocity step, damping, and the per-cell zone, shell and absorber decisions.
// Depends on lwcu_pkg.
module lwcu_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  lwcu_pkg::cfg_t cfg,
	input  logic signed [31:0] wave_u,
	input  logic signed [31:0] wave_v,
	input  logic signed [12:0] radius,
	input  logic [1:0] distance_status,
	input  logic [11:0] pulse_radius,
	input  logic [31:0] tick,
	input  logic signed [31:0] nbr_x_plus,
	input  logic signed [31:0] nbr_x_minus,
	input  logic signed [31:0] nbr_y_plus,
	input  logic signed [31:0] nbr_y_minus,
	input  logic signed [31:0] nbr_z_plus,
	input  logic signed [31:0] nbr_z_minus,
	output logic vld_out,
	output lwcu_pkg::front_t front
);
	import lwcu_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1
	logic [31:0] u_s1, v_s1, p01_s1, p23_s1, p45_s1, u6_s1;
	logic signed [12:0] r_s1;
	logic dead_s1, active_s1, tick0_s1;
	logic [4:0] dshift_s1;
	logic [13:0] tinc_s1;
	// stage 2
	logic [31:0] u_s2, v_s2, suma_s2, sumb_s2, fa_s2, fb_s2;
	logic dead_s2, active_s2, tick0_s2, hit_s2, gt_s2, kill_s2;
	logic [4:0] dshift_s2, ashift_s2;
	logic [13:0] tinc_s2;
	// stage 3
	logic [31:0] u_s3, v_s3, lap_s3, f_s3;
	logic dead_s3, active_s3, kill_s3;
	logic [4:0] dshift_s3, ashift_s3;
	logic [13:0] tinc_s3;
	// stage 4
	logic [31:0] u_s4, vn_s4, f_s4;
	logic dead_s4, active_s4, kill_s4;
	logic [4:0] ashift_s4;
	logic [13:0] tinc_s4;
	// stage 5
	front_t fr_s5;

	// stage 1 logic
	logic is_centre, r_ge_max;
	logic signed [12:0] q_c, ds_full;
	logic [4:0] dshift_c;

	assign is_centre = (distance_status == 2'd1);
	assign r_ge_max = radius >= $signed({1'b0, cfg.radius_max});
	assign q_c = radius >>> cfg.div_shift;
	assign ds_full = 13'sd5 - q_c;
	assign dshift_c = (q_c >= 13'sd2) ? 5'd3 :
		(q_c <= -13'sd26) ? 5'd31 : ds_full[4:0];

	// stage 2 logic: shell distance, absorber band, forcing operands
	logic signed [13:0] sh_diff, sh_adiff, abs_t;
	logic signed [12:0] rma;
	logic abs_on, hit_c, kill_c;
	logic [4:0] ashift_c;

	assign sh_diff = {r_s1[12], r_s1} - $signed({4'b0, cfg.shell_r});
	assign sh_adiff = sh_diff[13] ? -sh_diff : sh_diff;
	assign hit_c = sh_adiff <= $signed({4'b0, cfg.shell_w});
	assign rma = $signed({1'b0, cfg.radius_max}) - $signed({5'b0, cfg.absorb_w});
	assign abs_on = ({4'b0, cfg.absorb_w} < cfg.radius_max) && (r_s1 > rma);
	assign abs_t = {r_s1[12], r_s1} - {rma[12], rma};
	assign kill_c = abs_on && ((abs_t >= $signed({6'b0, cfg.absorb_w})) || (abs_t >= 14'sd32));
	assign ashift_c = abs_on ? abs_t[4:0] : 5'd0;

	// stage 3 logic: forcing term as an addend
	logic [31:0] f_c;
	always_comb begin
		f_c = '0;
		if (hit_s2) begin
			if (gt_s2) begin
				f_c = 32'(32'd0 - asr32(fa_s2, 5'd4));
			end else if (tick0_s2) begin
				f_c = 32'(asr32(fb_s2, 5'd10) + 32'd1);
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			u_s1 <= wave_u;
			v_s1 <= wave_v;
			p01_s1 <= 32'(nbr_x_plus + nbr_x_minus);
			p23_s1 <= 32'(nbr_y_plus + nbr_y_minus);
			p45_s1 <= 32'(nbr_z_plus + nbr_z_minus);
			u6_s1 <= 32'({wave_u[29:0], 2'b00} + {wave_u[30:0], 1'b0});
			r_s1 <= radius;
			dead_s1 <= !is_centre && (radius[12] || r_ge_max);
			active_s1 <= (distance_status != 2'd0) && !radius[12]
				&& (radius[11:0] == pulse_radius);
			tick0_s1 <= (tick[1:0] == 2'd0);
			dshift_s1 <= dshift_c;
			tinc_s1 <= 14'(tick[13:0] + 14'd1);
			// stage 2
			u_s2 <= u_s1;
			v_s2 <= v_s1;
			suma_s2 <= 32'(p01_s1 + p23_s1);
			sumb_s2 <= 32'(p45_s1 - u6_s1);
			fa_s2 <= 32'(u_s1 - FORCE_LEVEL);
			fb_s2 <= 32'(FORCE_LEVEL - u_s1);
			gt_s2 <= $signed(u_s1) > FORCE_LEVEL;
			hit_s2 <= hit_c;
			kill_s2 <= kill_c;
			ashift_s2 <= ashift_c;
			dead_s2 <= dead_s1;
			active_s2 <= active_s1;
			tick0_s2 <= tick0_s1;
			dshift_s2 <= dshift_s1;
			tinc_s2 <= tinc_s1;
			// stage 3
			u_s3 <= u_s2;
			v_s3 <= v_s2;
			lap_s3 <= 32'(suma_s2 + sumb_s2);
			f_s3 <= f_c;
			dead_s3 <= dead_s2;
			active_s3 <= active_s2;
			kill_s3 <= kill_s2;
			dshift_s3 <= dshift_s2;
			ashift_s3 <= ashift_s2;
			tinc_s3 <= tinc_s2;
			// stage 4
			u_s4 <= u_s3;
			vn_s4 <= 32'(v_s3 + asr32(lap_s3, dshift_s3));
			f_s4 <= f_s3;
			dead_s4 <= dead_s3;
			active_s4 <= active_s3;
			kill_s4 <= kill_s3;
			ashift_s4 <= ashift_s3;
			tinc_s4 <= tinc_s3;
			// stage 5: velocity damping shift is div_shift + 3
			fr_s5.un <= 32'(u_s4 + vn_s4);
			fr_s5.vd <= 32'(vn_s4 - asr32(vn_s4, 5'({2'b00, cfg.div_shift} + 5'd3)));
			fr_s5.force_v <= f_s4;
			fr_s5.abs_shift <= ashift_s4;
			fr_s5.abs_kill <= kill_s4;
			fr_s5.dead <= dead_s4;
			fr_s5.active <= active_s4;
			fr_s5.tick_inc <= tinc_s4;
		end
	end

	assign vld_out = vld_s5;
	assign front = fr_s5;

endmodule

### design/lwcu_back.sv
// Back half of the cell update pipeline, stages 6 to 10: shell forcing, absorber
// division toward zero, global damping, dead zone, sieve test and output register.
// Depends on lwcu_pkg.
module lwcu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  lwcu_pkg::front_t front,
	output logic vld_out,
	output logic signed [31:0] next_u,
	output logic signed [31:0] next_v,
	output logic active,
	output logic sieve_trigger
);
	import lwcu_pkg::*;

	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	logic [31:0] mag_s6, vn_s6;
	logic neg_s6, kill_s6, dead_s6, active_s6;
	logic [4:0] ashift_s6;
	logic [13:0] tinc_s6;

	logic [31:0] ua_s7, vn_s7;
	logic dead_s7, active_s7;
	logic [13:0] tinc_s7;

	logic [31:0] uf_s8, vf_s8;
	logic active_s8;
	logic [13:0] tinc_s8;

	logic [31:0] uf_s9, vf_s9;
	logic active_s9;
	logic [13:0] prod_s9;

	logic [31:0] uf_s10, vf_s10;
	logic active_s10, trig_s10;

	logic [31:0] sh_c, ua_c, uf_c, vf_c;
	logic [27:0] prod_c;
	logic pos_c;

	// magnitude shift then restore sign: division by 2^d toward zero
	assign sh_c = mag_s6 >> ashift_s6;
	assign ua_c = kill_s6 ? 32'd0 : (neg_s6 ? 32'(32'd0 - sh_c) : sh_c);
	assign uf_c = 32'(ua_s7 - asr32(ua_s7, 5'd12));
	assign vf_c = 32'(vn_s7 - asr32(vn_s7, 5'd12));
	// only the low 14 bits of the product matter for the mod 16384 test
	assign prod_c = 28'(uf_s8[13:0]) * 28'(tinc_s8);
	assign pos_c = !uf_s9[31] && (uf_s9 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_in;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 6
			vn_s6 <= 32'(front.vd + front.force_v);
			neg_s6 <= front.un[31];
			mag_s6 <= front.un[31] ? 32'(32'd0 - front.un) : front.un;
			kill_s6 <= front.abs_kill;
			ashift_s6 <= front.abs_shift;
			dead_s6 <= front.dead;
			active_s6 <= front.active;
			tinc_s6 <= front.tick_inc;
			// stage 7
			ua_s7 <= ua_c;
			vn_s7 <= vn_s6;
			dead_s7 <= dead_s6;
			active_s7 <= active_s6;
			tinc_s7 <= tinc_s6;
			// stage 8: global damping, dead zone forces zero
			uf_s8 <= dead_s7 ? 32'd0 : uf_c;
			vf_s8 <= dead_s7 ? 32'd0 : vf_c;
			active_s8 <= active_s7;
			tinc_s8 <= tinc_s7;
			// stage 9
			uf_s9 <= uf_s8;
			vf_s9 <= vf_s8;
			active_s9 <= active_s8;
			prod_s9 <= prod_c[13:0];
			// stage 10: any positive amplitude of 16384 or more always passes
			uf_s10 <= uf_s9;
			vf_s10 <= vf_s9;
			active_s10 <= active_s9;
			trig_s10 <= active_s9 && pos_c
				&& ((uf_s9[30:14] != '0) || (prod_s9 < uf_s9[13:0]));
		end
	end

	assign vld_out = vld_s10;
	assign next_u = $signed(uf_s10);
	assign next_v = $signed(vf_s10);
	assign active = active_s10;
	assign sieve_trigger = trig_s10;

endmodule

### design/lattice_wave_cell_update_top.sv
// Lattice wave cell update, top level.
// Throughput: one word per cycle while the output word is not stalled.
// The ten-stage pipeline advances as a whole; it holds while the output word is stalled.
// Reset clears all valid bits and loads max_radius = 64 with its derived values.
// Depends on lwcu_pkg, lwcu_cfg, lwcu_front, lwcu_back.
module lattice_wave_cell_update_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lwcu_pkg::CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] wave_u,
	input  logic signed [31:0] wave_v,
	input  logic signed [12:0] radius,
	input  logic [1:0] distance_status,
	input  logic [11:0] pulse_radius,
	input  logic [31:0] tick,
	input  logic signed [31:0] nbr_x_plus,
	input  logic signed [31:0] nbr_x_minus,
	input  logic signed [31:0] nbr_y_plus,
	input  logic signed [31:0] nbr_y_minus,
	input  logic signed [31:0] nbr_z_plus,
	input  logic signed [31:0] nbr_z_minus,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] next_u,
	output logic signed [31:0] next_v,
	output logic active,
	output logic sieve_trigger
);
	import lwcu_pkg::*;

	cfg_t cfg;
	front_t front;
	logic front_vld;
	logic en;

	// pipeline moves unless a finished word is held at the output
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	lwcu_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	lwcu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(in_valid),
		.cfg(cfg),
		.wave_u(wave_u),
		.wave_v(wave_v),
		.radius(radius),
		.distance_status(distance_status),
		.pulse_radius(pulse_radius),
		.tick(tick),
		.nbr_x_plus(nbr_x_plus),
		.nbr_x_minus(nbr_x_minus),
		.nbr_y_plus(nbr_y_plus),
		.nbr_y_minus(nbr_y_minus),
		.nbr_z_plus(nbr_z_plus),
		.nbr_z_minus(nbr_z_minus),
		.vld_out(front_vld),
		.front(front)
	);

	lwcu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(front_vld),
		.front(front),
		.vld_out(out_valid),
		.next_u(next_u),
		.next_v(next_v),
		.active(active),
		.sieve_trigger(sieve_trigger)
	);

endmodule

### sim/lattice_wave_cell_update_top_tb.sv
// Self-checking testbench for lattice_wave_cell_update_top: directed table, then random phases
// over a range of max_radius settings, checked against known words or an in-bench predictor.
// Depends on lwcu_pkg and the lattice_wave_cell_update_top RTL.
module lattice_wave_cell_update_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lwcu_pkg::*;

	localparam logic [1:0] ST_UNREACHED = 2'd0;
	localparam logic [1:0] ST_CENTRE = 2'd1;
	localparam logic [1:0] ST_ORDINARY = 2'd2;
	localparam logic [1:0] ST_RESERVED = 2'd3;
	localparam int PHASE_ITEMS = 38;

	typedef struct {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic signed [12:0] radius;
		logic [1:0] status;
		logic [11:0] pulse;
		logic [31:0] tick;
		logic signed [31:0] n_xp;
		logic signed [31:0] n_xm;
		logic signed [31:0] n_yp;
		logic signed [31:0] n_ym;
		logic signed [31:0] n_zp;
		logic signed [31:0] n_zm;
	} cell_in_t;

	typedef struct {
		logic signed [31:0] next_u;
		logic signed [31:0] next_v;
		logic active;
		logic trig;
	} cell_out_t;

	typedef struct {
		cell_in_t stim;
		bit known;
		cell_out_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] wave_u = '0;
	logic signed [31:0] wave_v = '0;
	logic signed [12:0] radius = '0;
	logic [1:0] distance_status = '0;
	logic [11:0] pulse_radius = '0;
	logic [31:0] tick = '0;
	logic signed [31:0] nbr_x_plus = '0;
	logic signed [31:0] nbr_x_minus = '0;
	logic signed [31:0] nbr_y_plus = '0;
	logic signed [31:0] nbr_y_minus = '0;
	logic signed [31:0] nbr_z_plus = '0;
	logic signed [31:0] nbr_z_minus = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] next_u;
	logic signed [31:0] next_v;
	logic active;
	logic sieve_trigger;

	logic [CFG_W-1:0] max_radius_shadow;
	cell_out_t expected_updates[$];
	dir_row_t directed_rows[$];
	int error_count = 0;
	bit no_idle = 1'b0;
	int hold_off_cycles = 0;

	lattice_wave_cell_update_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.wave_u(wave_u),
		.wave_v(wave_v),
		.radius(radius),
		.distance_status(distance_status),
		.pulse_radius(pulse_radius),
		.tick(tick),
		.nbr_x_plus(nbr_x_plus),
		.nbr_x_minus(nbr_x_minus),
		.nbr_y_plus(nbr_y_plus),
		.nbr_y_minus(nbr_y_minus),
		.nbr_z_plus(nbr_z_plus),
		.nbr_z_minus(nbr_z_minus),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_u(next_u),
		.next_v(next_v),
		.active(active),
		.sieve_trigger(sieve_trigger)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// arithmetic right shift, shift counts past 31 give a pure sign fill
	function automatic logic [31:0] sra_clamped(logic [31:0] x, int s);
		if (s > 31) s = 31;
		return $signed(x) >>> s;
	endfunction

	function automatic logic [31:0] div_pow2_toward_zero(logic [31:0] x, int d);
		logic [31:0] mag;
		if (d >= 32) return '0;
		if (x[31]) begin
			mag = (32'd0 - x) >> d;
			return 32'd0 - mag;
		end
		return x >> d;
	endfunction

	function automatic int effective_radius(logic [CFG_W-1:0] reg_val);
		return (reg_val == '0) ? 1 : int'(reg_val);
	endfunction

	function automatic cell_out_t predict_cell_update(cell_in_t c, logic [CFG_W-1:0] reg_val);
		int rm, shell_r, shell_w, absorb_w, div_sh, q, dsh, dr, t, r;
		logic [31:0] sum, lap, vn, un;
		logic [63:0] prod;
		logic reached, centre, on_pulse, trig;
		cell_out_t o;
		rm = effective_radius(reg_val);
		shell_r = rm * 24 / 100;
		shell_w = rm / 5;
		if (shell_w < 1) shell_w = 1;
		absorb_w = (rm / 27 > 2) ? rm / 27 : 2;
		if (rm >= 384) div_sh = 6;
		else if (rm >= 192) div_sh = 5;
		else if (rm >= 96) div_sh = 4;
		else if (rm >= 40) div_sh = 3;
		else div_sh = 2;
		r = int'(c.radius);
		reached = (c.status != ST_UNREACHED);
		centre = (c.status == ST_CENTRE);
		on_pulse = reached && r >= 0 && r == int'(c.pulse);
		o.active = on_pulse;
		if (!centre && (r < 0 || r >= rm)) begin
			o.next_u = '0;
			o.next_v = '0;
			o.trig = 1'b0;
			return o;
		end
		sum = c.n_xp + c.n_xm + c.n_yp + c.n_ym + c.n_zp + c.n_zm;
		lap = sum - c.u * 32'd6;
		q = r >>> div_sh; // floor division, r may be negative for a center cell
		dsh = 5 - q;
		if (dsh < 3) dsh = 3;
		vn = c.v + sra_clamped(lap, dsh);
		un = c.u + vn;
		vn = vn - sra_clamped(vn, div_sh + 3);
		dr = r - shell_r;
		if (dr < 0) dr = -dr;
		if (dr <= shell_w) begin
			if ($signed(c.u) > FORCE_LEVEL) begin
				vn = vn - sra_clamped(c.u - FORCE_LEVEL, 4);
			end else if (c.tick[1:0] == 2'd0) begin
				vn = vn + sra_clamped(FORCE_LEVEL - c.u, 10) + 32'd1;
			end
		end
		if (rm > absorb_w && r > rm - absorb_w) begin
			t = r - (rm - absorb_w);
			if (t >= absorb_w) un = '0;
			else if (t > 0) un = div_pow2_toward_zero(un, t);
		end
		un = un - sra_clamped(un, 12);
		vn = vn - sra_clamped(vn, 12);
		trig = 1'b0;
		if ($signed(un) > 0) begin
			prod = {32'd0, un} * {32'd0, c.tick + 32'd1};
			trig = ({18'd0, prod[13:0]} < un);
		end
		o.next_u = un;
		o.next_v = vn;
		o.trig = on_pulse && trig;
		return o;
	endfunction

	function automatic cell_in_t mk_cell(logic [31:0] u, logic [31:0] v, int r, logic [1:0] st,
			int pl, logic [31:0] tk, logic [31:0] xp, logic [31:0] xm, logic [31:0] yp,
			logic [31:0] ym, logic [31:0] zp, logic [31:0] zm);
		cell_in_t c;
		c.u = u;
		c.v = v;
		c.radius = 13'(r);
		c.status = st;
		c.pulse = 12'(pl);
		c.tick = tk;
		c.n_xp = xp;
		c.n_xm = xm;
		c.n_yp = yp;
		c.n_ym = ym;
		c.n_zp = zp;
		c.n_zm = zm;
		return c;
	endfunction

	function automatic logic [31:0] random_amplitude(int mode, logic [31:0] base);
		case (mode)
			0: begin
				return base + 32'($urandom_range(0, 4000)) - 32'd2000;
			end
			1: begin
				return $urandom;
			end
			default: begin
				return base + 32'($urandom_range(0, 200)) - 32'd100;
			end
		endcase
	endfunction

	function automatic cell_in_t random_cell(logic [CFG_W-1:0] reg_val);
		cell_in_t c;
		int rm, pick, mode;
		logic [31:0] base;
		rm = effective_radius(reg_val);
		pick = $urandom_range(0, 9);
		if (pick < 6) c.radius = 13'($urandom_range(0, rm));
		else if (pick < 8) c.radius = 13'(rm - int'($urandom_range(0, rm / 27 + 3)));
		else c.radius = 13'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 6) c.status = ST_ORDINARY;
		else if (pick < 8) c.status = ST_CENTRE;
		else if (pick == 8) c.status = ST_UNREACHED;
		else c.status = ST_RESERVED;
		c.pulse = ($urandom_range(0, 1) == 0) ? c.radius[11:0] : 12'($urandom);
		c.tick = $urandom;
		mode = $urandom_range(0, 2);
		if (mode == 0) base = FORCE_LEVEL;
		else if (mode == 1) base = $urandom;
		else base = 32'($urandom_range(0, 4000)) - 32'd2000;
		c.u = random_amplitude(mode == 1 ? 0 : mode, base);
		c.v = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 512)) - 32'd256;
		c.n_xp = random_amplitude(mode, base);
		c.n_xm = random_amplitude(mode, base);
		c.n_yp = random_amplitude(mode, base);
		c.n_ym = random_amplitude(mode, base);
		c.n_zp = random_amplitude(mode, base);
		c.n_zm = random_amplitude(mode, base);
		return c;
	endfunction

	task automatic send_cell(cell_in_t c, bit known, cell_out_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		wave_u <= c.u;
		wave_v <= c.v;
		radius <= c.radius;
		distance_status <= c.status;
		pulse_radius <= c.pulse;
		tick <= c.tick;
		nbr_x_plus <= c.n_xp;
		nbr_x_minus <= c.n_xm;
		nbr_y_plus <= c.n_yp;
		nbr_y_minus <= c.n_ym;
		nbr_z_plus <= c.n_zp;
		nbr_z_minus <= c.n_zm;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_updates.push_back(known ? want : predict_cell_update(c, max_radius_shadow));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_updates.size() != 0) @(posedge clk);
	endtask

	// block is idle here: every word sent has come back
	task automatic write_max_radius(logic [CFG_W-1:0] value);
		wait_for_results();
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		max_radius_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch on %s: expected %h, got %h", what, want, got);
		end
	endtask

	// output side: random stall per word, one long hold-off on request
	initial begin
		int gap;
		cell_out_t exp_word;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (hold_off_cycles > 0) begin
				gap = hold_off_cycles;
				hold_off_cycles = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_updates.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("output word with nothing expected: next_u %h next_v %h", next_u, next_v);
			end else begin
				exp_word = expected_updates.pop_front();
				flag_field("next_u", exp_word.next_u, next_u);
				flag_field("next_v", exp_word.next_v, next_v);
				flag_field("active", 32'(exp_word.active), 32'(active));
				flag_field("sieve_trigger", 32'(exp_word.trig), 32'(sieve_trigger));
			end
		end
	end

	initial begin
		#3ms;
		$display("lattice_wave_cell_update_top regression: fail");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] settings[13];
		cell_out_t none;
		none = '{next_u: '0, next_v: '0, active: 1'b0, trig: 1'b0};
		settings = '{12'd64, 12'd0, 12'd4095, 12'd1, 12'd39, 12'd40, 12'd95, 12'd96,
			12'd191, 12'd192, 12'd383, 12'd384, 12'($urandom_range(1, 4095))};
		max_radius_shadow = RESET_MAX_RADIUS;

		// at reset radius 64: shell at 15 +/- 12, absorber width 2, divider shift 3
		directed_rows.push_back('{mk_cell(0, 0, -1, ST_UNREACHED, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, none});
		directed_rows.push_back('{mk_cell(32'h7fffffff, 32'h80000000, 4095, ST_ORDINARY, 4095,
			32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff), 1'b1, '{'0, '0, 1'b1, 1'b0}});
		directed_rows.push_back('{mk_cell(16384, 5, 64, ST_RESERVED, 64, 0, 9, 9, 9, 9, 9, 9),
			1'b1, '{'0, '0, 1'b1, 1'b0}});
		directed_rows.push_back('{mk_cell(0, 0, 0, ST_ORDINARY, 0, 1, 0, 0, 0, 0, 0, 0),
			1'b1, '{'0, '0, 1'b1, 1'b0}});
		directed_rows.push_back('{mk_cell(-1, -1, 4095, ST_UNREACHED, 4095, 0,
			1, 2, 3, 4, 5, 6), 1'b1, none});
		directed_rows.push_back('{mk_cell(1000, -7, -1, ST_CENTRE, 0, 0,
			5000, -3000, 77, 12, -900, 40000), 1'b0, none});
		directed_rows.push_back('{mk_cell(32'h80000000, 32'h7fffffff, -4096, ST_CENTRE, 4095, 4,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000), 1'b0, none});
		directed_rows.push_back('{mk_cell(123456, 999, 4095, ST_CENTRE, 4095, 7,
			100, 200, 300, 400, 500, 600), 1'b0, none});
		directed_rows.push_back('{mk_cell(-12345, 20, 63, ST_ORDINARY, 63, 9,
			-12000, -12500, -13000, -11000, -12345, -12345), 1'b0, none});
		directed_rows.push_back('{mk_cell(100000, 0, 15, ST_ORDINARY, 15, 1,
			100000, 100000, 99000, 101000, 100000, 100000), 1'b0, none});
		directed_rows.push_back('{mk_cell(-5, 3, 15, ST_ORDINARY, 15, 0,
			0, 0, -10, -10, 4, 4), 1'b0, none});
		directed_rows.push_back('{mk_cell(16384, 0, 27, ST_ORDINARY, 27, 4,
			16384, 16384, 16384, 16384, 16384, 16384), 1'b0, none});
		directed_rows.push_back('{mk_cell(16385, 0, 3, ST_ORDINARY, 3, 3,
			16000, 17000, 16385, 16385, 16385, 16385), 1'b0, none});
		directed_rows.push_back('{mk_cell(5000, 100, 28, ST_ORDINARY, 28, 3,
			5100, 4900, 5000, 5000, 6000, 4000), 1'b0, none});
		directed_rows.push_back('{mk_cell(20000, 1, 40, ST_ORDINARY, 40, 32'hffffffff,
			20000, 20000, 20000, 20000, 20000, 20000), 1'b0, none});
		directed_rows.push_back('{mk_cell(32'h80000000, 0, 1, ST_ORDINARY, 2, 8,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff), 1'b0, none});
		directed_rows.push_back('{mk_cell(32'h7fffffff, 0, 2, ST_ORDINARY, 2, 12,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000), 1'b0, none});
		directed_rows.push_back('{mk_cell(16383, 32'h7fffffff, 10, ST_ORDINARY, 10, 16383,
			16383, 16383, 16383, 16383, 16383, 16383), 1'b0, none});
		directed_rows.push_back('{mk_cell(777, -777, 62, ST_ORDINARY, 62, 5,
			700, 800, 777, 777, 900, 600), 1'b0, none});
		directed_rows.push_back('{mk_cell(1, 0, 0, ST_CENTRE, 0, 16383, 1, 1, 1, 1, 1, 1),
			1'b0, none});
		directed_rows.push_back('{mk_cell(40000, -40000, 5, ST_RESERVED, 5, 2,
			41000, 39000, 40000, 40000, 38000, 42000), 1'b0, none});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_cell(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].want);

		foreach (settings[p]) begin
			write_max_radius(settings[p]);
			if (p == 2) begin
				// hold the output long enough for the pipe to fill and stall the input
				no_idle = 1'b1;
				hold_off_cycles = 80;
			end
			if (p == 5) no_idle = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_cell(random_cell(max_radius_shadow), 1'b0, none);
			no_idle = 1'b0;
		end

		wait_for_results();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_updates.size() == 0)
			$display("lattice_wave_cell_update_top regression: pass");
		else
			$display("lattice_wave_cell_update_top regression: fail");
		$finish;
	end

endmodule

### lattice_wave_cell_update_top.f
design/lwcu_pkg.sv
design/lwcu_cfg.sv
design/lwcu_front.sv
design/lwcu_back.sv
design/lattice_wave_cell_update_top.sv
sim/lattice_wave_cell_update_top_tb.sv
